/* src/pud_pkg.sv */
// Shared types, constants and helpers for the packed code dequantizer.
package pud_pkg;

    localparam int GROUP_CODES = 8;
    localparam int IDX_W       = 3;
    localparam int CNT_W       = 4;
    localparam int DEPTH_W     = 4;
    localparam int CODE_W      = 8;
    localparam int FP_W        = 32;
    localparam int MANT_W      = 64;
    localparam int EXP_W       = 12;

    localparam logic [DEPTH_W-1:0] DEPTH_MIN = 4'd4;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 4'd8;
    localparam logic [CNT_W-1:0]   CNT_MAX   = 4'd8;

    localparam logic [FP_W-1:0] DEFAULT_NAN = 32'h7FC0_0000;
    localparam logic [FP_W-1:0] QUIET_BIT   = 32'h0040_0000;
    localparam logic [FP_W-1:0] INF_BITS    = 32'h7F80_0000;

    typedef enum logic [1:0] {
        REG_DEPTH  = 2'd0,
        REG_SCALE  = 2'd1,
        REG_OFFSET = 2'd2
    } cfg_reg_t;

    // One code handed from the group register to the arithmetic pipeline
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [CODE_W-1:0] code;
    } pud_issue_t;

    // Index of the highest set bit, 0 for a zero word
    function automatic logic [6:0] top_bit64(input logic [MANT_W-1:0] v);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < MANT_W; i++) begin
            if (v[i]) n = 7'(i);
        end
        return n;
    endfunction

    function automatic logic is_nan(input logic [FP_W-1:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != '0);
    endfunction

    function automatic logic is_inf(input logic [FP_W-1:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] == '0);
    endfunction

endpackage

/* src/pud_fma.sv */
// Six-stage fused float32 multiply-add of scale by a code plus offset.
module pud_fma (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  pud_pkg::pud_issue_t      issue,
    input  logic [pud_pkg::FP_W-1:0] scale_bits,
    input  logic [pud_pkg::FP_W-1:0] offset_bits,
    output logic                     out_valid,
    output logic [pud_pkg::FP_W-1:0] out_value,
    output logic                     out_last
);
    import pud_pkg::*;

    // decode of configuration (user keeps it stable while items in flight)
    logic              sa, sb;
    logic [23:0]       mant_a, mant_b;
    logic signed [EXP_W-1:0] exp_a, exp_b;

    assign sa     = scale_bits[31];
    assign sb     = offset_bits[31];
    assign mant_a = (scale_bits[30:23] == '0) ? {1'b0, scale_bits[22:0]}
                                              : {1'b1, scale_bits[22:0]};
    assign mant_b = (offset_bits[30:23] == '0) ? {1'b0, offset_bits[22:0]}
                                               : {1'b1, offset_bits[22:0]};
    assign exp_a  = (scale_bits[30:23] == '0) ? -EXP_W'(149)
                  : $signed({4'd0, scale_bits[30:23]}) - EXP_W'(150);
    assign exp_b  = (offset_bits[30:23] == '0) ? -EXP_W'(149)
                  : $signed({4'd0, offset_bits[30:23]}) - EXP_W'(150);

    // stage 1: product and NaN/infinity results
    logic            fix1;
    logic [FP_W-1:0] fix1_val;

    always_comb begin
        fix1     = 1'b1;
        fix1_val = '0;
        if (is_nan(offset_bits) && !offset_bits[22]) begin
            fix1_val = offset_bits | QUIET_BIT;
        end else if (is_nan(scale_bits) && !scale_bits[22]) begin
            fix1_val = scale_bits | QUIET_BIT;
        end else if (is_nan(offset_bits)) begin
            fix1_val = (is_inf(scale_bits) && issue.code == '0) ? DEFAULT_NAN : offset_bits;
        end else if (is_nan(scale_bits)) begin
            fix1_val = scale_bits;
        end else if (is_inf(scale_bits)) begin
            if (issue.code == '0) begin
                fix1_val = DEFAULT_NAN;
            end else if (is_inf(offset_bits) && sa != sb) begin
                fix1_val = DEFAULT_NAN;
            end else begin
                fix1_val = {sa, 31'd0} | INF_BITS;
            end
        end else if (is_inf(offset_bits)) begin
            fix1_val = offset_bits;
        end else begin
            fix1 = 1'b0;
        end
    end

    logic              v1_reg, last1_reg, fix1_reg;
    logic [FP_W-1:0]   fixv1_reg;
    logic [31:0]       prod1_reg;

    // stage 2: normalize both operands to bit 62
    logic              za2, zb2, fix2;
    logic [FP_W-1:0]   fix2_val;
    logic [6:0]        ta2, tb2;
    logic [MANT_W-1:0] ma2, mb2;
    logic signed [EXP_W-1:0] ea2, eb2;

    always_comb begin
        za2 = (prod1_reg == '0);
        zb2 = (mant_b == '0);
        ta2 = top_bit64({32'd0, prod1_reg});
        tb2 = top_bit64({40'd0, mant_b});
        ma2 = {32'd0, prod1_reg} << (7'd62 - ta2);
        mb2 = {40'd0, mant_b} << (7'd62 - tb2);
        ea2 = exp_a - $signed({5'd0, 7'd62 - ta2});
        eb2 = exp_b - $signed({5'd0, 7'd62 - tb2});
        fix2     = fix1_reg;
        fix2_val = fixv1_reg;
        if (!fix1_reg && za2 && zb2) begin
            fix2     = 1'b1;
            fix2_val = (sa && sb) ? 32'h8000_0000 : 32'h0;
        end
    end

    logic              v2_reg, last2_reg, fix2_reg, za2_reg, zb2_reg;
    logic [FP_W-1:0]   fixv2_reg;
    logic [MANT_W-1:0] ma2_reg, mb2_reg;
    logic signed [EXP_W-1:0] ea2_reg, eb2_reg;

    // stage 3: order by exponent, align the smaller operand with sticky
    logic              swap3, sbig3, ssml3, zsml3;
    logic [MANT_W-1:0] mbig3, msml3, mal3, lost3;
    logic signed [EXP_W-1:0] ebig3, esml3, d3;

    always_comb begin
        swap3 = za2_reg || (!zb2_reg && (eb2_reg > ea2_reg));
        mbig3 = swap3 ? mb2_reg : ma2_reg;
        msml3 = swap3 ? ma2_reg : mb2_reg;
        ebig3 = swap3 ? eb2_reg : ea2_reg;
        esml3 = swap3 ? ea2_reg : eb2_reg;
        sbig3 = swap3 ? sb : sa;
        ssml3 = swap3 ? sa : sb;
        zsml3 = swap3 ? za2_reg : zb2_reg;
        d3    = ebig3 - esml3;
        lost3 = '0;
        if (zsml3) begin
            mal3 = '0;
        end else if (d3 >= EXP_W'(64)) begin
            mal3 = 64'd1;
        end else begin
            lost3 = msml3 & ((64'd1 << d3[5:0]) - 64'd1);
            mal3  = (msml3 >> d3[5:0]) | {63'd0, lost3 != '0};
        end
    end

    logic              v3_reg, last3_reg, fix3_reg, sbig3_reg, ssml3_reg;
    logic [FP_W-1:0]   fixv3_reg;
    logic [MANT_W-1:0] mbig3_reg, mal3_reg;
    logic signed [EXP_W-1:0] e3_reg;

    // stage 4: add or subtract magnitudes
    logic              fix4, s4;
    logic [FP_W-1:0]   fix4_val;
    logic [MANT_W-1:0] m4;

    always_comb begin
        fix4     = fix3_reg;
        fix4_val = fixv3_reg;
        s4       = sbig3_reg;
        if (sbig3_reg == ssml3_reg) begin
            m4 = mbig3_reg + mal3_reg;
        end else if (mbig3_reg == mal3_reg) begin
            m4 = '0;
            if (!fix3_reg) begin
                fix4     = 1'b1;
                fix4_val = '0;
            end
        end else if (mbig3_reg > mal3_reg) begin
            m4 = mbig3_reg - mal3_reg;
        end else begin
            m4 = mal3_reg - mbig3_reg;
            s4 = ssml3_reg;
        end
    end

    logic              v4_reg, last4_reg, fix4_reg, s4_reg;
    logic [FP_W-1:0]   fixv4_reg;
    logic [MANT_W-1:0] m4_reg;
    logic signed [EXP_W-1:0] e4_reg;

    // stage 5: rounding shift, limited at the subnormal floor
    logic signed [EXP_W-1:0] sh5;

    always_comb begin
        sh5 = $signed({5'd0, top_bit64(m4_reg)}) - EXP_W'(23);
        if (e4_reg + sh5 < -EXP_W'(149)) sh5 = -EXP_W'(149) - e4_reg;
    end

    logic              v5_reg, last5_reg, fix5_reg, s5_reg;
    logic [FP_W-1:0]   fixv5_reg;
    logic [MANT_W-1:0] m5_reg;
    logic signed [EXP_W-1:0] e5_reg, sh5_reg;

    // stage 6: round to nearest even and pack
    logic [MANT_W-1:0] q6w, low6;
    logic [24:0]       q6;
    logic              guard6, sticky6;
    logic signed [EXP_W-1:0] el6, ef6;
    logic [FP_W-1:0]   val6;

    always_comb begin
        guard6  = 1'b0;
        sticky6 = 1'b0;
        low6    = '0;
        if (sh5_reg <= 0) begin
            q6w = m5_reg << 6'(-sh5_reg);
        end else begin
            q6w     = m5_reg >> sh5_reg[5:0];
            guard6  = m5_reg[6'(sh5_reg - EXP_W'(1))];
            low6    = m5_reg & ((64'd1 << 6'(sh5_reg - EXP_W'(1))) - 64'd1);
            sticky6 = (low6 != '0);
        end
        q6  = q6w[24:0] + {24'd0, guard6 && (sticky6 || q6w[0])};
        el6 = e5_reg + sh5_reg;
        if (q6[24]) begin
            q6  = q6 >> 1;
            el6 = el6 + EXP_W'(1);
        end
        ef6 = el6 + EXP_W'(149);
        if (q6[23] && (el6 + EXP_W'(150) >= EXP_W'(255))) begin
            val6 = {s5_reg, 31'd0} | INF_BITS;
        end else begin
            val6 = {s5_reg, 31'd0} | ((32'(ef6) << 23) + {8'd0, q6[23:0]});
        end
        if (fix5_reg) val6 = fixv5_reg;
    end

    logic            out_valid_reg, out_last_reg;
    logic [FP_W-1:0] out_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= issue.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            out_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            last1_reg <= issue.last;
            fix1_reg  <= fix1;
            fixv1_reg <= fix1_val;
            prod1_reg <= {8'd0, mant_a} * {24'd0, issue.code};

            last2_reg <= last1_reg;
            fix2_reg  <= fix2;
            fixv2_reg <= fix2_val;
            za2_reg   <= za2;
            zb2_reg   <= zb2;
            ma2_reg   <= ma2;
            mb2_reg   <= mb2;
            ea2_reg   <= ea2;
            eb2_reg   <= eb2;

            last3_reg <= last2_reg;
            fix3_reg  <= fix2_reg;
            fixv3_reg <= fixv2_reg;
            sbig3_reg <= sbig3;
            ssml3_reg <= ssml3;
            mbig3_reg <= mbig3;
            mal3_reg  <= mal3;
            e3_reg    <= ebig3;

            last4_reg <= last3_reg;
            fix4_reg  <= fix4;
            fixv4_reg <= fix4_val;
            s4_reg    <= s4;
            m4_reg    <= m4;
            e4_reg    <= e3_reg;

            last5_reg <= last4_reg;
            fix5_reg  <= fix4_reg;
            fixv5_reg <= fixv4_reg;
            s5_reg    <= s4_reg;
            m5_reg    <= m4_reg;
            e5_reg    <= e4_reg;
            sh5_reg   <= sh5;

            out_last_reg  <= last5_reg;
            out_value_reg <= val6;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule

/* src/packed_uint_dequantizer.sv */
// Code j of a group is presented after the group register, then six FMA register stages ending in
// the output register; codes issue in index order and the whole path holds while the output stalls.
// Throughput: one result per cycle while the output is not stalled; a group occupies the group register
// until its last code issues, and the next group is taken as that last code issues.
// Groups with a count of zero are taken and yield nothing.
// Reset (aresetn low, synchronous) empties the group register and every pipeline valid bit
// and loads depth 8, scale 1.0 and offset +0.0.
module packed_uint_dequantizer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [31:0]                 cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [63:0]                 s_packed_group,
    input  logic [pud_pkg::CNT_W-1:0]   s_valid_count,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pud_pkg::FP_W-1:0]    m_value_bits,
    output logic                        m_last_of_group
);
    import pud_pkg::*;

    logic [DEPTH_W-1:0] depth_reg;
    logic [FP_W-1:0]    scale_reg, offset_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg  <= DEPTH_MAX;
            scale_reg  <= 32'h3F80_0000;
            offset_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_DEPTH:  depth_reg  <= cfg_data[DEPTH_W-1:0];
                REG_SCALE:  scale_reg  <= cfg_data;
                REG_OFFSET: offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic               en;
    logic               g_valid_reg, g_valid_next;
    logic [63:0]        g_packed_reg, g_packed_next;
    logic [CNT_W-1:0]   g_cnt_reg, g_cnt_next, cnt_in;
    logic [IDX_W-1:0]   g_idx_reg, g_idx_next, last_idx;
    logic               last_issue, accept;
    logic [DEPTH_W-1:0] dq;
    logic [5:0]         amt;
    logic [CODE_W-1:0]  mask;
    pud_issue_t         issue;

    // the whole pipeline holds while a result waits at the output
    assign en         = !m_valid || m_ready;
    assign last_idx   = IDX_W'(g_cnt_reg - CNT_W'(1));
    assign last_issue = (g_idx_reg == last_idx);
    assign s_ready    = !g_valid_reg || (en && last_issue);
    assign accept     = s_valid && s_ready;
    assign cnt_in     = (s_valid_count > CNT_MAX) ? CNT_MAX : s_valid_count;

    always_comb begin
        dq = depth_reg;
        if (depth_reg < DEPTH_MIN) dq = DEPTH_MIN;
        if (depth_reg > DEPTH_MAX) dq = DEPTH_MAX;
        amt  = {3'd0, g_idx_reg} * {2'd0, dq};
        mask = CODE_W'((9'd1 << dq) - 9'd1);
        issue.valid = g_valid_reg;
        issue.last  = last_issue;
        issue.code  = CODE_W'(g_packed_reg >> amt) & mask;
    end

    always_comb begin
        g_valid_next  = g_valid_reg;
        g_packed_next = g_packed_reg;
        g_cnt_next    = g_cnt_reg;
        g_idx_next    = g_idx_reg;
        if (accept) begin
            g_valid_next  = (cnt_in != '0);
            g_packed_next = s_packed_group;
            g_cnt_next    = cnt_in;
            g_idx_next    = '0;
        end else if (g_valid_reg && en) begin
            if (last_issue) begin
                g_valid_next = 1'b0;
            end else begin
                g_idx_next = g_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_valid_reg <= 1'b0;
            g_cnt_reg   <= '0;
            g_idx_reg   <= '0;
        end else begin
            g_valid_reg <= g_valid_next;
            g_cnt_reg   <= g_cnt_next;
            g_idx_reg   <= g_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        g_packed_reg <= g_packed_next;
    end

    pud_fma u_fma (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .issue      (issue),
        .scale_bits (scale_reg),
        .offset_bits(offset_reg),
        .out_valid  (m_valid),
        .out_value  (m_value_bits),
        .out_last   (m_last_of_group)
    );

    a_idx_in_group: assert property (@(posedge aclk) disable iff (!aresetn)
        g_valid_reg |-> ({1'b0, g_idx_reg} < g_cnt_reg))
        else $error("code index past group count");

    a_group_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        g_valid_reg |-> (g_cnt_reg != '0))
        else $error("empty group held for issue");

    a_stall_holds_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && g_valid_reg) |=> (g_valid_reg && $stable(g_idx_reg)))
        else $error("issue advanced during output stall");

endmodule

/* tb/packed_uint_dequantizer_tb.sv */
// Self-checking testbench for packed_uint_dequantizer: directed and randomized groups and FMA predictor.
module packed_uint_dequantizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pud_pkg::*;

    localparam int    LIMIT    = 400000;
    localparam int    SETTLE   = 12;
    localparam int    HALF_CLK = 6;

    typedef struct {
        logic [31:0] value;
        logic        last;
    } dq_result_t;

    class dequant_scoreboard;
        logic [3:0]  depth;
        logic [31:0] scale;
        logic [31:0] offset;
        dq_result_t  pending_values[$];
        int          errors;
        int          groups;
        int          results;
        int          writes;

        function new();
            depth  = 4'd8;
            scale  = 32'h3F80_0000;
            offset = 32'h0000_0000;
            errors = 0;
            groups = 0;
            results = 0;
            writes = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [31:0] data);
            writes++;
            case (idx)
                REG_DEPTH:  depth  = data[3:0];
                REG_SCALE:  scale  = data;
                REG_OFFSET: offset = data;
                default: ;
            endcase
        endfunction

        static function int msb64(logic [63:0] v);
            int n;
            n = -1;
            for (int i = 0; i < 64; i++) if (v[i]) n = i;
            return n;
        endfunction

        static function logic f_nan(logic [31:0] b);
            return b[30:23] == 8'hFF && b[22:0] != 0;
        endfunction

        static function logic f_inf(logic [31:0] b);
            return b[30:0] == 31'h7F80_0000;
        endfunction

        // Round sign * m * 2^e to float32, nearest even, subnormals kept
        static function logic [31:0] round_f32(logic [31:0] sign, logic [63:0] m, int e);
            int          sh;
            int          el;
            logic [63:0] q;
            logic [63:0] rem;
            logic [63:0] half;
            logic [63:0] packed_word;
            sh = msb64(m) - 23;
            if (e + sh < -149) sh = -149 - e;
            if (sh <= 0) begin
                q = m << (-sh);
            end else begin
                if (sh > 64) begin
                    m = 64'd1;
                    sh = 64;
                end
                if (sh == 64) begin
                    q = 0;
                    rem = m;
                    half = 64'd1 << 63;
                end else begin
                    q = m >> sh;
                    rem = m & ((64'd1 << sh) - 1);
                    half = 64'd1 << (sh - 1);
                end
                if (rem > half || (rem == half && q[0])) q++;
            end
            el = e + sh;
            if (q >= (64'd1 << 24)) begin
                q = q >> 1;
                el++;
            end
            if (q >= (64'd1 << 23) && el + 150 >= 255) return sign | INF_BITS;
            packed_word = (64'(32'(el + 149)) << 23) + q;
            return sign | packed_word[31:0];
        endfunction

        static function void split_f32(logic [31:0] b, output logic [63:0] m, output int e);
            if (b[30:23] == 0) begin
                m = {41'd0, b[22:0]};
                e = -149;
            end else begin
                m = {40'd0, 1'b1, b[22:0]};
                e = int'(b[30:23]) - 150;
            end
        endfunction

        // scale*code+offset with one rounding
        static function logic [31:0] scaled_code(logic [31:0] sc, logic [31:0] off,
                                                 logic [7:0] code);
            logic [31:0] sa, sb, ts;
            logic [63:0] ma, mb, tm, lost;
            int          ea, eb, d, te;
            sa = sc & 32'h8000_0000;
            sb = off & 32'h8000_0000;
            if (f_nan(off) && !off[22]) return off | QUIET_BIT;
            if (f_nan(sc) && !sc[22]) return sc | QUIET_BIT;
            if (f_nan(off)) return (f_inf(sc) && code == 0) ? DEFAULT_NAN : off;
            if (f_nan(sc)) return sc;
            if (f_inf(sc)) begin
                if (code == 0) return DEFAULT_NAN;
                if (f_inf(off) && sb != sa) return DEFAULT_NAN;
                return sa | INF_BITS;
            end
            if (f_inf(off)) return off;
            split_f32(sc, ma, ea);
            ma = ma * {56'd0, code};
            split_f32(off, mb, eb);
            if (ma == 0 && mb == 0) return (sa != 0 && sb != 0) ? 32'h8000_0000 : 32'h0;
            if (ma == 0) return round_f32(sb, mb, eb);
            if (mb == 0) return round_f32(sa, ma, ea);
            d = 62 - msb64(ma);
            ma = ma << d;
            ea -= d;
            d = 62 - msb64(mb);
            mb = mb << d;
            eb -= d;
            if (eb > ea) begin
                tm = ma; te = ea; ts = sa;
                ma = mb; ea = eb; sa = sb;
                mb = tm; eb = te; sb = ts;
            end
            d = ea - eb;
            if (d >= 64) begin
                mb = 64'd1;
            end else if (d > 0) begin
                lost = mb & ((64'd1 << d) - 1);
                mb = (mb >> d) | {63'd0, lost != 0};
            end
            if (sa == sb) return round_f32(sa, ma + mb, ea);
            if (ma == mb) return 32'h0;
            if (ma > mb) return round_f32(sa, ma - mb, ea);
            return round_f32(sb, mb - ma, ea);
        endfunction

        function void note_group(logic [63:0] packed_group, logic [3:0] count);
            int         d;
            int         n;
            logic [7:0] code;
            dq_result_t r;
            d = (depth < 4) ? 4 : (depth > 8) ? 8 : int'(depth);
            n = (count > 8) ? 8 : int'(count);
            groups++;
            for (int j = 0; j < n; j++) begin
                code = 8'((packed_group >> (j * d)) & ((64'd1 << d) - 1));
                r.value = scaled_code(scale, offset, code);
                r.last = (j + 1 == n);
                pending_values.push_back(r);
            end
        endfunction

        function void check_result(logic [31:0] value, logic last);
            dq_result_t r;
            results++;
            if (pending_values.size() == 0) begin
                $error("unexpected result value_bits=%h last_of_group=%b", value, last);
                errors++;
                return;
            end
            r = pending_values.pop_front();
            if (value !== r.value) begin
                $error("value_bits: expected %h, actual %h", r.value, value);
                errors++;
            end
            if (last !== r.last) begin
                $error("last_of_group: expected %b, actual %b", r.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_reg_t    cfg_index;
    logic [31:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_packed_group;
    logic [CNT_W-1:0] s_valid_count;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_value_bits;
    logic        m_last_of_group;

    dequant_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int hold_left;
    int cycle_count;

    packed_uint_dequantizer i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_packed_group  (s_packed_group),
        .s_valid_count   (s_valid_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_value_bits    (m_value_bits),
        .m_last_of_group (m_last_of_group)
    );

    always begin
        aclk = 1'b1;
        #HALF_CLK;
        aclk = 1'b0;
        #HALF_CLK;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold when requested
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready = 1'b0;
        end else begin
            m_ready = aresetn && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_value_bits, m_last_of_group);
    end

    task automatic wait_drained();
        while (sb.pending_values.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(logic [3:0] depth, logic [31:0] scale, logic [31:0] offset);
        wait_drained();
        write_reg(REG_DEPTH, {28'd0, depth});
        write_reg(REG_SCALE, scale);
        write_reg(REG_OFFSET, offset);
    endtask

    // Called at a falling edge; returns at a falling edge once the group has been accepted
    task automatic send_group(logic [63:0] packed_group, logic [3:0] count);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < idle_pct) gap++;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_packed_group = packed_group;
        s_valid_count = count;
        do @(posedge aclk); while (!s_ready);
        sb.note_group(packed_group, count);
        @(negedge aclk);
    endtask

    task automatic end_burst();
        s_valid = 1'b0;
    endtask

    function automatic logic [31:0] rand_f32();
        case ($urandom_range(0, 11))
            0:  return {$urandom_range(0, 1) == 1, 31'h0};
            1:  return {$urandom_range(0, 1) == 1, 31'h7F80_0000};
            2:  return {$urandom_range(0, 1) == 1, 9'h1FF, 22'($urandom)};
            3:  return {$urandom_range(0, 1) == 1, 9'h1FE, 22'($urandom) | 22'd1};
            4:  return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom)};
            5:  return {$urandom_range(0, 1) == 1, 8'($urandom_range(240, 254)), 23'($urandom)};
            6:  return {$urandom_range(0, 1) == 1, 8'($urandom_range(1, 8)), 23'($urandom)};
            7:  return $urandom;
            default: return {$urandom_range(0, 1) == 1,
                             8'($urandom_range(118, 134)), 23'($urandom) & 23'h7F_0000};
        endcase
    endfunction

    task automatic random_phase(int items, int hold_at, int pause_at);
        logic [3:0] cnt;
        set_config(4'($urandom_range(0, 15)), rand_f32(), rand_f32());
        @(negedge aclk);
        for (int i = 0; i < items; i++) begin
            if (i == hold_at) hold_left = 300;
            if (i == pause_at) begin
                end_burst();
                while (sb.pending_values.size() != 0) @(negedge aclk);
            end
            if (i % 20 == 19) begin
                end_burst();
                set_config(($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                       : 4'($urandom_range(4, 8)),
                           rand_f32(), rand_f32());
                @(negedge aclk);
            end
            cnt = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
            send_group({$urandom, $urandom}, cnt);
        end
        end_burst();
    endtask

    task automatic directed_case(logic [3:0] depth, logic [31:0] scale, logic [31:0] offset,
                                 logic [63:0] packed_group, logic [3:0] count);
        set_config(depth, scale, offset);
        @(negedge aclk);
        send_group(packed_group, count);
        end_burst();
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_DEPTH;
        cfg_data = '0;
        s_valid = 1'b0;
        s_packed_group = '0;
        s_valid_count = '0;
        m_ready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        cycle_count = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings first, then field extremes and the arithmetic corner cases
        @(negedge aclk);
        send_group('0, 4'd8);
        send_group('1, 4'd8);
        send_group(64'h0123_4567_89AB_CDEF, 4'd1);
        send_group(64'hFEDC_BA98_7654_3210, 4'd0);
        send_group(64'hA5A5_A5A5_A5A5_A5A5, 4'd15);
        end_burst();
        directed_case(4'd4, 32'h3F80_0000, 32'h0, 64'hFFFF_FFFF_7654_3210, 4'd8);
        directed_case(4'd5, 32'h4000_0000, 32'h3F00_0000, '1, 4'd5);
        directed_case(4'd7, 32'hBF80_0000, 32'h4120_0000, 64'h00FF_FFFF_FFFF_FFFF, 4'd8);
        directed_case(4'd0, 32'h3F80_0000, 32'h0, 64'h8765_4321, 4'd8);
        directed_case(4'd15, 32'h3F80_0000, 32'h0, 64'hFF00_7F80_0102_0304, 4'd8);
        directed_case(4'd8, 32'h3F80_0000, 32'h7F80_0001, 64'h0102, 4'd2);
        directed_case(4'd8, 32'h7FA0_0000, 32'h3F80_0000, 64'h0102, 4'd2);
        directed_case(4'd8, 32'h7F80_0000, 32'h7FC1_2345, 64'h0100, 4'd2);
        directed_case(4'd8, 32'hFFC0_1234, 32'h3F80_0000, 64'h0100, 4'd2);
        directed_case(4'd8, 32'hFF80_0000, 32'h3F80_0000, 64'h0300, 4'd2);
        directed_case(4'd8, 32'h7F80_0000, 32'hFF80_0000, 64'h0001, 4'd2);
        directed_case(4'd8, 32'h7F80_0000, 32'h7F80_0000, 64'h0001, 4'd1);
        directed_case(4'd8, 32'h4000_0000, 32'hFF80_0000, 64'h0502, 4'd2);
        directed_case(4'd8, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 64'hFF02, 4'd2);
        directed_case(4'd8, 32'h3F80_0000, 32'hC040_0000, 64'h0403_0201, 4'd4);
        directed_case(4'd8, 32'h8000_0000, 32'h8000_0000, 64'h0500, 4'd2);
        directed_case(4'd8, 32'h0000_0001, 32'h8000_0003, 64'hFF05_0403_0201_00, 4'd8);
        directed_case(4'd8, 32'h3F80_0001, 32'hCB80_0000, 64'hFF80_0301, 4'd4);

        idle_pct = 0;  stall_pct = 0;  random_phase(78, 10, -1);
        idle_pct = 72; stall_pct = 0;  random_phase(78, -1, 40);
        idle_pct = 0;  stall_pct = 72; random_phase(78, -1, -1);
        idle_pct = 25; stall_pct = 25; random_phase(78, 50, 30);

        wait_drained();
        $display("covered %0d groups and %0d results under %0d register writes,",
                 sb.groups, sb.results, sb.writes);
        $display("across depths 0..15, float special values and four idle/stall mixes");
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
